/* rtl/sr2t_pkg.sv */
// Shared types, constants and symbol helpers for the signed radix-to-text block.
// No dependencies; the front, back and top-level files import this package.
package sr2t_pkg;

    // Default build values, handed to the top-level parameters.
    localparam int VALUE_BITS_DEF  = 32;
    localparam int MAX_SYMBOLS_DEF = 62;

    // Alphabet layout: seven words of nine 7-bit symbols each.
    localparam int SYM_BITS      = 7;
    localparam int SYMS_PER_WORD = 9;
    localparam int WORD_COUNT    = 7;
    localparam int SYMS_TOTAL    = WORD_COUNT * SYMS_PER_WORD;
    localparam int CFG_DATA_W    = SYMS_PER_WORD * SYM_BITS;
    localparam int ALPHA_W       = WORD_COUNT * CFG_DATA_W;
    localparam int WORD_SEL_W    = $clog2(WORD_COUNT);
    localparam int SEEN_W        = 2 ** SYM_BITS;

    // Symbol count / radix / digit value width.
    localparam int CNT_W       = 6;
    localparam int MIN_SYMBOLS = 2;

    // Configuration port.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FIRST  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LAST   = CFG_IDX_W'(7);

    // Divider: quotient bits retired per cycle; decoupling queue depth.
    localparam int STEP_BITS   = 4;
    localparam int QUEUE_DEPTH = 2;

    // Output stream byte.
    localparam int OUT_DATA_W = 8;

    // ASCII codes.
    localparam logic [SYM_BITS-1:0] CHAR_MINUS   = 7'h2D;
    localparam logic [SYM_BITS-1:0] CHAR_NEWLINE = 7'h0A;
    localparam logic [SYM_BITS-1:0] ASCII_DIGIT_LO = 7'd48;
    localparam logic [SYM_BITS-1:0] ASCII_DIGIT_HI = 7'd57;
    localparam logic [SYM_BITS-1:0] ASCII_UPPER_LO = 7'd65;
    localparam logic [SYM_BITS-1:0] ASCII_UPPER_HI = 7'd90;
    localparam logic [SYM_BITS-1:0] ASCII_LOWER_LO = 7'd97;
    localparam logic [SYM_BITS-1:0] ASCII_LOWER_HI = 7'd122;

    // Radix and alphabet, from the front part to the back part.
    typedef struct packed {
        logic [CNT_W-1:0]   radix;
        logic [ALPHA_W-1:0] alphabet;
    } t_cfg;

    // Pick symbol idx out of the flat alphabet; slots past the last word read as zero.
    function automatic logic [SYM_BITS-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
                                                   input logic [CNT_W-1:0]   idx);
        logic [SYM_BITS-1:0] c;
        c = '0;
        if (idx < CNT_W'(SYMS_TOTAL)) begin
            c = alpha[idx * SYM_BITS +: SYM_BITS];
        end
        return c;
    endfunction

    function automatic logic is_alnum(input logic [SYM_BITS-1:0] c);
        return ((c >= ASCII_DIGIT_LO) && (c <= ASCII_DIGIT_HI)) ||
               ((c >= ASCII_UPPER_LO) && (c <= ASCII_UPPER_HI)) ||
               ((c >= ASCII_LOWER_LO) && (c <= ASCII_LOWER_HI));
    endfunction

endpackage

/* rtl/sr2t_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sr2t_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sr2t_fifo.sv */
// Short first-in first-out queue that decouples the front and back parts.
// No dependencies.
module sr2t_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [LVL_W-1:0] r_lvl, n_lvl;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_lvl = r_lvl;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_lvl = r_lvl + 1'b1;
        end else if (i_pop && !i_push) begin
            n_lvl = r_lvl - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_lvl <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_lvl <= n_lvl;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_lvl == LVL_W'(DEPTH));
    assign o_valid = (r_lvl != '0);
    assign o_data  = r_mem[r_rd];

endmodule

/* rtl/sr2t_front.sv */
// Front part: configuration registers, alphabet check sweep, input accept and
// sign/magnitude split. Depends on sr2t_pkg.
module sr2t_front
    import sr2t_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                         i_s_valid,
    output logic                         o_s_ready,
    input  logic signed [VALUE_BITS-1:0] i_s_value,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output logic [VALUE_BITS:0]          o_q_data,
    output t_cfg                         o_cfg
);

    logic [CNT_W-1:0]      r_count, n_count;
    logic [CFG_DATA_W-1:0] r_word [WORD_COUNT];
    logic [CFG_DATA_W-1:0] n_word [WORD_COUNT];
    logic                  r_busy, n_busy;
    logic                  r_ok, n_ok;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [SEEN_W-1:0]     r_seen, n_seen;

    logic [ALPHA_W-1:0]    w_alpha;
    logic [CFG_IDX_W-1:0]  w_sel;
    logic [SYM_BITS-1:0]   w_sym;
    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_neg;

    always_comb begin
        for (int k = 0; k < WORD_COUNT; k++) begin
            w_alpha[k * CFG_DATA_W +: CFG_DATA_W] = r_word[k];
        end
    end

    assign w_sel = i_cfg_idx - REG_ALPHA_FIRST;
    assign w_sym = sym_at(w_alpha, r_idx);

    // Any write restarts the check; the sweep walks one symbol a cycle.
    always_comb begin
        n_count = r_count;
        n_word  = r_word;
        n_busy  = r_busy;
        n_ok    = r_ok;
        n_idx   = r_idx;
        n_seen  = r_seen;
        if (i_cfg_we) begin
            if (i_cfg_idx == REG_SYMBOL_COUNT) begin
                n_count = i_cfg_wdata[CNT_W-1:0];
            end else if (i_cfg_idx <= REG_ALPHA_LAST) begin
                n_word[w_sel[WORD_SEL_W-1:0]] = i_cfg_wdata;
            end
            n_busy = 1'b1;
            n_ok   = 1'b1;
            n_idx  = '0;
            n_seen = '0;
        end else if (r_busy) begin
            if ((r_count < CNT_W'(MIN_SYMBOLS)) || (r_count > CNT_W'(MAX_SYMBOLS))) begin
                n_ok   = 1'b0;
                n_busy = 1'b0;
            end else if (r_idx == r_count) begin
                n_busy = 1'b0;
            end else begin
                if (!is_alnum(w_sym) || r_seen[w_sym]) begin
                    n_ok = 1'b0;
                end
                n_seen[w_sym] = 1'b1;
                n_idx         = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < WORD_COUNT; k++) begin
                r_word[k] <= '0;
            end
            r_busy <= 1'b0;
            r_ok   <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_count <= n_count;
            r_word  <= n_word;
            r_busy  <= n_busy;
            r_ok    <= n_ok;
            r_idx   <= n_idx;
        end
        r_seen <= n_seen;
    end

    // Split sign and magnitude; the most negative value maps to 2^(N-1).
    assign w_raw = $unsigned(i_s_value);
    assign w_neg = w_raw[VALUE_BITS-1];
    assign w_mag = w_neg ? (~w_raw + 1'b1) : w_raw;

    // Drop items that arrive under an invalid alphabet.
    assign o_s_ready      = !r_busy && !i_q_full;
    assign o_q_push       = i_s_valid && o_s_ready && r_ok;
    assign o_q_data       = {w_neg, w_mag};
    assign o_cfg.radix    = r_count;
    assign o_cfg.alphabet = w_alpha;

endmodule

/* rtl/sr2t_back.sv */
// Back part: iterative divider filling the digit store, then the character
// emitter with its output register. Depends on sr2t_pkg and sr2t_ram.
module sr2t_back
    import sr2t_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  logic [VALUE_BITS:0] i_q_data,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [SYM_BITS-1:0] o_m_char,
    output logic                o_m_last
);

    localparam int DIV_STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W     = DIV_STEPS * STEP_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int ADDR_W    = $clog2(VALUE_BITS);
    localparam int TOT_W     = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_RD,
        S_CHAR,
        S_NL
    } t_state;

    t_state              r_state, n_state;
    logic [DIV_W-1:0]    r_div, n_div;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_neg, n_neg;
    logic [TOT_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_k, n_k;
    logic                r_out_valid, n_out_valid;
    logic [SYM_BITS-1:0] r_out_char, n_out_char;
    logic                r_out_last, n_out_last;

    logic [DIV_W-1:0]    w_div;
    logic [CNT_W-1:0]    w_rem;
    logic [CNT_W:0]      w_t;
    logic [TOT_W-1:0]    w_last_idx;
    logic                w_slot;
    logic                w_we;
    logic                w_re;
    logic [CNT_W-1:0]    w_rdata;

    // Retire STEP_BITS quotient bits: shift dividend top bit into the remainder.
    always_comb begin
        w_div = r_div;
        w_rem = r_rem;
        w_t   = '0;
        for (int j = 0; j < STEP_BITS; j++) begin
            w_t = {w_rem, w_div[DIV_W-1]};
            if (w_t >= {1'b0, i_cfg.radix}) begin
                w_rem = CNT_W'(w_t - {1'b0, i_cfg.radix});
                w_div = {w_div[DIV_W-2:0], 1'b1};
            end else begin
                w_rem = w_t[CNT_W-1:0];
                w_div = {w_div[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign w_last_idx = r_cnt - 1'b1;
    assign w_slot     = !r_out_valid || i_m_ready;

    always_comb begin
        n_state     = r_state;
        n_div       = r_div;
        n_rem       = r_rem;
        n_step      = r_step;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        if (r_out_valid && i_m_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_div   = DIV_W'(i_q_data[VALUE_BITS-1:0]);
                    n_neg   = i_q_data[VALUE_BITS];
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_div  = w_div;
                n_rem  = w_rem;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    // Store the digit, keep the quotient as the next dividend.
                    w_we   = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_step = '0;
                    n_rem  = '0;
                    if (w_div == '0) begin
                        n_state = S_SIGN;
                    end
                end
            end
            S_SIGN: begin
                n_k = w_last_idx[ADDR_W-1:0];
                if (!r_neg) begin
                    n_state = S_RD;
                end else if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                w_re    = 1'b1;
                n_state = S_CHAR;
            end
            S_CHAR: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sym_at(i_cfg.alphabet, w_rdata);
                    n_out_last  = 1'b0;
                    if (r_k == '0) begin
                        n_state = S_NL;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_NL: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_NEWLINE;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_neg      <= n_neg;
        r_k        <= n_k;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    sr2t_ram #(
        .WIDTH (CNT_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (w_rem),
        .i_re    (w_re),
        .i_raddr (r_k),
        .o_rdata (w_rdata)
    );

    assign o_m_valid = r_out_valid;
    assign o_m_char  = r_out_char;
    assign o_m_last  = r_out_last;

endmodule

/* rtl/signed_radix_to_text_top.sv */
// Top level of the signed radix-to-text converter: front, queue and back.
// Depends on sr2t_pkg, sr2t_front, sr2t_fifo, sr2t_back (and sr2t_ram below it).
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+---------------------------------
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready| tdata: number_in
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready| tdata: char_out; tlast: final_char
//  cfg       | in  | i_cfg_we (no wait)             | i_cfg_idx, i_cfg_wdata
//
// Each config write starts an alphabet check, and s_axis tready stays low meanwhile.
// A number is popped from the queue and divided into digits by the divide loop
// (4 quotient bits per cycle). Then the sign for a negative number, each digit read
// back from the digit RAM (most significant first) and the newline are emitted.
// Reset (synchronous, active low) clears all control state and the configuration.
// The two-entry queue lets the front take numbers while the back works, and the
// output register holds a character until the sink takes the transaction.
module signed_radix_to_text_top
    import sr2t_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [CFG_IDX_W-1:0]               i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]              i_cfg_wdata,
    // Input stream. tdata: number_in (two's complement), zero padding above.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    // Output stream. tdata: char_out [6:0], zero pad [7]. tlast: final_char.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]              o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    t_cfg                w_cfg;
    logic                w_push;
    logic [VALUE_BITS:0] w_push_data;
    logic                w_full;
    logic                w_pop;
    logic                w_q_valid;
    logic [VALUE_BITS:0] w_q_data;
    logic [SYM_BITS-1:0] w_char;

    // Accept, check and classify; drop numbers under an invalid alphabet.
    sr2t_front #(
        .VALUE_BITS  (VALUE_BITS),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_s_value   ($signed(i_s_axis_tdata[VALUE_BITS-1:0])),
        .i_q_full    (w_full),
        .o_q_push    (w_push),
        .o_q_data    (w_push_data),
        .o_cfg       (w_cfg)
    );

    // Hold sign and magnitude until the back is free.
    sr2t_fifo #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // Divide into digits, then emit sign, digits and newline.
    sr2t_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_pop),
        .i_q_data  (w_q_data),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_char  (w_char),
        .o_m_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - SYM_BITS)'(0), w_char};

`ifndef SYNTHESIS
    // A config write must hold off the input until the alphabet check is done.
    a_cfg_blocks_input: assert property (@(posedge i_clk)
        (i_rst_n && i_cfg_we) |=> !o_s_axis_tready)
        else $error("input ready right after a configuration write");

    // The front never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue push while full");

    // The back only pops an entry that is there.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue pop while empty");

    // A closing character is always the newline.
    a_last_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (w_char == CHAR_NEWLINE))
        else $error("tlast on a character other than newline");
`endif

endmodule
